// ----- design/led_pattern_blinker_macros.svh -----
`ifndef LED_PATTERN_BLINKER_MACROS_SVH
`define LED_PATTERN_BLINKER_MACROS_SVH

// concurrent check on an explicit clock and active-low reset
`define LPB_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lpb check failed");

// concurrent check on the block clock and reset
`define LPB_ASSERT(lbl, prop) \
  `LPB_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// ----- design/lpb_pkg.sv -----
package lpb_pkg;

  localparam int unsigned MaxSteps = 16;
  localparam int unsigned LenW = 5;
  localparam int unsigned IdxW = 4;
  localparam int unsigned AddrW = 5;

  localparam logic [LenW-1:0] LenCap = LenW'(MaxSteps > 16 ? 16 : MaxSteps);
  localparam logic [31:0] HoldMs = 32'd100;
  localparam logic [31:0] MsPerSec = 32'd1000;

  localparam logic [1:0] CmdStep = 2'd0;
  localparam logic [1:0] CmdStart = 2'd1;
  localparam logic [1:0] CmdStop = 2'd2;

  localparam logic [1:0] ModeStopped = 2'd0;
  localparam logic [1:0] ModeForever = 2'd1;
  localparam logic [1:0] ModeTimer = 2'd2;
  localparam logic [1:0] ModeCounter = 2'd3;

  localparam logic [1:0] PhaseDrive = 2'd0;
  localparam logic [1:0] PhaseHold = 2'd1;
  localparam logic [1:0] PhaseNext = 2'd2;

  localparam logic [1:0] LampKeep = 2'd0;
  localparam logic [1:0] LampOn = 2'd1;
  localparam logic [1:0] LampOff = 2'd2;

  localparam logic [1:0] ReasonNone = 2'd0;
  localparam logic [1:0] ReasonAbort = 2'd1;
  localparam logic [1:0] ReasonExpire = 2'd2;

  localparam logic [2:0] RegSteps = 3'd0;
  localparam logic [2:0] RegLength = 3'd1;
  localparam logic [2:0] RegKind = 3'd2;
  localparam logic [2:0] RegLimit = 3'd3;
  localparam logic [2:0] RegActiveLow = 3'd4;

  typedef struct packed {
    logic [1:0]  command;
    logic        condition;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic pin_level;
    logic ok;
    logic expired;
    logic aborted;
    logic running;
  } out_t;

  typedef struct packed {
    logic [31:0]     pattern_steps;
    logic [LenW-1:0] pattern_length;
    logic            run_kind;
    logic [15:0]     run_limit;
    logic [31:0]     limit_ms;
    logic            active_low;
  } cfg_t;

  typedef struct packed {
    logic [1:0]      run_mode;
    logic            started;
    logic [1:0]      phase;
    logic [IdxW-1:0] step_index;
    logic [31:0]     step_start_ms;
    logic [31:0]     end_ms;
    logic [15:0]     passes_left;
    logic            lamp_on;
    logic [1:0]      end_reason;
  } state_t;

endpackage

// ----- design/lpb_step.sv -----
module lpb_step (
  input  lpb_pkg::cfg_t   cfg_i,
  input  lpb_pkg::state_t state_i,
  input  lpb_pkg::in_t    word_i,
  output lpb_pkg::state_t state_o,
  output lpb_pkg::out_t   result_o
);

  logic [lpb_pkg::LenW-1:0] len;
  logic                     do_adv;
  logic                     adv_ok;
  logic [31:0]              end_ms;
  logic [lpb_pkg::LenW-1:0] idx_inc;
  logic [lpb_pkg::IdxW-1:0] idx_cur;
  logic [1:0]               code;
  lpb_pkg::state_t          s;

  assign len = (cfg_i.pattern_length > lpb_pkg::LenCap) ? lpb_pkg::LenCap
                                                         : cfg_i.pattern_length;

  always_comb begin
    s = state_i;
    do_adv = 1'b0;
    adv_ok = 1'b1;
    end_ms = state_i.started ? state_i.end_ms
                             : word_i.now_ms + cfg_i.limit_ms;
    idx_inc = '0;
    idx_cur = '0;
    code = lpb_pkg::LampKeep;

    unique case (word_i.command)
      lpb_pkg::CmdStart: begin
        s.started = 1'b0;
        s.phase = lpb_pkg::PhaseDrive;
        s.step_index = '0;
        s.passes_left = cfg_i.run_limit;
        if (cfg_i.run_limit == '0) begin
          s.run_mode = lpb_pkg::ModeForever;
        end else begin
          s.run_mode = cfg_i.run_kind ? lpb_pkg::ModeCounter : lpb_pkg::ModeTimer;
        end
      end
      lpb_pkg::CmdStop: begin
        if (len != '0) s.lamp_on = 1'b0;
        s.end_reason = lpb_pkg::ReasonAbort;
        s.run_mode = lpb_pkg::ModeStopped;
      end
      lpb_pkg::CmdStep: begin
        unique case (state_i.run_mode)
          lpb_pkg::ModeCounter: begin
            if (state_i.passes_left == '0) begin
              if (len != '0) s.lamp_on = 1'b0;
              s.end_reason = lpb_pkg::ReasonExpire;
              s.run_mode = lpb_pkg::ModeStopped;
            end else begin
              do_adv = 1'b1;
            end
          end
          lpb_pkg::ModeTimer: begin
            s.end_ms = end_ms;
            if (word_i.now_ms > end_ms) begin
              if (len != '0) s.lamp_on = 1'b0;
              s.end_reason = lpb_pkg::ReasonExpire;
              s.run_mode = lpb_pkg::ModeStopped;
            end else begin
              do_adv = 1'b1;
            end
          end
          lpb_pkg::ModeForever: do_adv = 1'b1;
          default: ;
        endcase
      end
      default: ;
    endcase

    if (do_adv) begin
      s.started = 1'b1;
      if (!word_i.condition) begin
        adv_ok = 1'b0;
        if (len != '0) s.lamp_on = 1'b0;
        s.run_mode = lpb_pkg::ModeStopped;
      end else if (len != '0) begin
        unique case (state_i.phase)
          lpb_pkg::PhaseHold: begin
            if (word_i.now_ms > state_i.step_start_ms + lpb_pkg::HoldMs) begin
              s.lamp_on = 1'b0;
              s.phase = lpb_pkg::PhaseNext;
            end
          end
          lpb_pkg::PhaseNext: begin
            idx_inc = lpb_pkg::LenW'(state_i.step_index) + lpb_pkg::LenW'(1);
            s.step_index = (idx_inc >= len) ? '0 : idx_inc[lpb_pkg::IdxW-1:0];
            s.phase = lpb_pkg::PhaseDrive;
          end
          default: begin
            idx_cur = (lpb_pkg::LenW'(state_i.step_index) >= len) ? '0
                                                                  : state_i.step_index;
            s.step_index = idx_cur;
            s.step_start_ms = word_i.now_ms;
            code = cfg_i.pattern_steps[{idx_cur, 1'b0} +: 2];
            if (code == lpb_pkg::LampOn) s.lamp_on = 1'b1;
            if (code == lpb_pkg::LampOff) s.lamp_on = 1'b0;
            s.phase = lpb_pkg::PhaseHold;
          end
        endcase
      end
      s.end_reason = adv_ok ? lpb_pkg::ReasonNone : lpb_pkg::ReasonAbort;
      if (state_i.run_mode == lpb_pkg::ModeCounter && s.phase == lpb_pkg::PhaseDrive &&
          s.step_index == '0) begin
        s.passes_left = s.passes_left - 16'd1;
      end
    end
  end

  assign state_o = s;

  assign result_o.pin_level = s.lamp_on ^ cfg_i.active_low;
  assign result_o.ok = (s.run_mode != lpb_pkg::ModeStopped);
  assign result_o.expired = s.end_reason[1];
  assign result_o.aborted = s.end_reason[0];
  assign result_o.running = (s.run_mode != lpb_pkg::ModeStopped);

endmodule

// ----- design/led_pattern_blinker.sv -----
// the result word is registered and appears in the cycle after its input word is accepted
// one word per cycle unless a result waits; the update is one compare and select pass
// the result register lets a new word enter while the previous result is being taken
// reset: asynchronous, active low; run stopped, lamp off, all but res_q at defaults
`include "led_pattern_blinker_macros.svh"

module led_pattern_blinker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  lpb_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output lpb_pkg::out_t               out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lpb_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  lpb_pkg::cfg_t   cfg_q;
  lpb_pkg::state_t state_q;
  lpb_pkg::state_t state_d;
  lpb_pkg::out_t   res_q;
  lpb_pkg::out_t   res_d;
  logic            res_valid_q;
  logic            in_accept;
  logic            cfg_wr;
  logic [2:0]      reg_idx;

  assign pready = 1'b1;
  assign reg_idx = paddr[lpb_pkg::AddrW-1:2];
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_steps <= 32'd41;
      cfg_q.pattern_length <= lpb_pkg::LenW'(3);
      cfg_q.run_kind <= 1'b0;
      cfg_q.run_limit <= '0;
      cfg_q.limit_ms <= '0;
      cfg_q.active_low <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        lpb_pkg::RegSteps: cfg_q.pattern_steps <= pwdata;
        lpb_pkg::RegLength: cfg_q.pattern_length <= pwdata[lpb_pkg::LenW-1:0];
        lpb_pkg::RegKind: cfg_q.run_kind <= pwdata[0];
        lpb_pkg::RegLimit: begin
          cfg_q.run_limit <= pwdata[15:0];
          cfg_q.limit_ms <= {16'd0, pwdata[15:0]} * lpb_pkg::MsPerSec;
        end
        lpb_pkg::RegActiveLow: cfg_q.active_low <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      lpb_pkg::RegSteps: prdata = cfg_q.pattern_steps;
      lpb_pkg::RegLength: prdata = 32'(cfg_q.pattern_length);
      lpb_pkg::RegKind: prdata = 32'(cfg_q.run_kind);
      lpb_pkg::RegLimit: prdata = 32'(cfg_q.run_limit);
      lpb_pkg::RegActiveLow: prdata = 32'(cfg_q.active_low);
      default: prdata = '0;
    endcase
  end

  assign in_ready_o = !res_valid_q || out_ready_i;
  assign in_accept = in_valid_i && in_ready_o;

  lpb_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .word_i   (in_data_i),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        state_q <= state_d;
        res_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o = res_q;

  `LPB_ASSERT(a_accept_gives_result, in_accept |=> res_valid_q)
  `LPB_ASSERT(a_reason_exclusive, res_valid_q |-> !(res_q.expired && res_q.aborted))
  `LPB_ASSERT(a_stop_ends_run,
    in_accept && in_data_i.command == lpb_pkg::CmdStop |=> !res_q.running && res_q.aborted)
  `LPB_ASSERT(a_ready_when_empty, !res_valid_q |-> in_ready_o)

endmodule
